>>> rtl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types, register indexes and the pixel depth decode used by the
// run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_DEPTH  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // depth codes
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [7:0] DEPTH_RESET = DEPTH_32;

    // one decoded result
    typedef struct packed {
        logic        overrun;
        logic        image_last;
        logic [7:0]  repeat_count;
        logic [31:0] pixel_value;
    } tga_result_t;

    // bytes per pixel for a depth code, unknown codes give four
    function automatic logic [2:0] bytes_per_pixel(input logic [7:0] depth);
        logic [2:0] bpp;
        case (depth)
            DEPTH_8:  bpp = 3'd1;
            DEPTH_16: bpp = 3'd2;
            DEPTH_24: bpp = 3'd3;
            DEPTH_32: bpp = 3'd4;
            default:  bpp = 3'd4;
        endcase
        return bpp;
    endfunction

endpackage

>>> rtl/tga_front.sv
// ----------------------------------------------------------------------------
// tga_front
// Accepts coded bytes, parses packet headers, assembles pixels and keeps the
// image pixel account; pushes finished results into the queue.
// ----------------------------------------------------------------------------
module tga_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,     // data_byte
    input  logic                 s_tuser,     // frame_start
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 queue_full,
    output logic                 res_valid,
    output tga_pkg::tga_result_t res
);
    import tga_pkg::*;

    logic [7:0]  depth_reg,  depth_next;
    logic [15:0] width_reg,  width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] total_reg,  total_next;
    logic        settle_reg, settle_next;

    logic        awaiting_reg, awaiting_next;
    logic        run_reg,      run_next;
    logic [7:0]  left_reg,     left_next;
    logic [1:0]  bidx_reg,     bidx_next;
    logic [31:0] asm_reg,      asm_next;
    logic [31:0] done_reg,     done_next;
    logic [31:0] rem_reg,      rem_next;
    logic        complete_reg, complete_next;
    logic        ended_reg,    ended_next;

    logic [15:0] mul_a, mul_b;
    logic        accept;

    // state as seen by this beat, after an optional frame clear
    logic        awaiting_e, run_e, ended_e;
    logic [7:0]  left_e;
    logic [1:0]  bidx_e;
    logic [31:0] asm_e, done_e, rem_e;

    logic [31:0] asm_new;
    logic [2:0]  idx;
    logic [7:0]  cnt0, cnt, left_dec;
    logic [31:0] rem_after;
    logic [32:0] diff;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !settle_reg && !queue_full;

    // config writes; the product is refreshed from the new value directly
    always_comb
    begin
        depth_next  = depth_reg;
        width_next  = width_reg;
        height_next = height_reg;
        mul_a       = width_reg;
        mul_b       = height_reg;
        settle_next = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEPTH:
                begin
                    depth_next = cfg_data[7:0];
                end
                CFG_WIDTH:
                begin
                    width_next  = cfg_data;
                    mul_a       = cfg_data;
                    settle_next = 1'b1;
                end
                CFG_HEIGHT:
                begin
                    height_next = cfg_data;
                    mul_b       = cfg_data;
                    settle_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        total_next = 32'(mul_a) * 32'(mul_b);
    end

    always_comb
    begin
        awaiting_e = s_tuser ? 1'b1 : awaiting_reg;
        run_e      = s_tuser ? 1'b0 : run_reg;
        left_e     = s_tuser ? 8'd0 : left_reg;
        bidx_e     = s_tuser ? 2'd0 : bidx_reg;
        asm_e      = s_tuser ? 32'd0 : asm_reg;
        done_e     = s_tuser ? 32'd0 : done_reg;
        rem_e      = s_tuser ? total_reg : rem_reg;
        ended_e    = s_tuser ? (total_reg == 32'd0) : ended_reg;

        asm_new = asm_e;
        asm_new[{bidx_e, 3'b000} +: 8] = asm_e[{bidx_e, 3'b000} +: 8] | s_tdata;
        idx      = {1'b0, bidx_e} + 3'd1;
        left_dec = left_e - 8'd1;

        cnt0 = run_e ? left_e : 8'd1;
        if (cnt0 == 8'd0)
        begin
            cnt0 = 8'd1;
        end
        cnt = cnt0;
        if ({24'd0, cnt0} > rem_e)
        begin
            cnt = rem_e[7:0];
        end
        rem_after = rem_e - {24'd0, cnt};

        diff = {1'b0, total_reg} - {1'b0, done_reg};

        awaiting_next = awaiting_reg;
        run_next      = run_reg;
        left_next     = left_reg;
        bidx_next     = bidx_reg;
        asm_next      = asm_reg;
        done_next     = done_reg;
        rem_next      = rem_reg;
        complete_next = complete_reg;
        ended_next    = ended_reg;

        res_valid        = 1'b0;
        res.pixel_value  = asm_new;
        res.repeat_count = cnt;
        res.image_last   = (rem_after == 32'd0);
        res.overrun      = ({24'd0, left_e} > rem_e);

        if (settle_reg)
        begin
            // image size changed: rebuild the account from the pixel count
            rem_next   = diff[31:0];
            ended_next = complete_reg || diff[32] || (diff[31:0] == 32'd0);
        end
        else if (accept)
        begin
            awaiting_next = awaiting_e;
            run_next      = run_e;
            left_next     = left_e;
            bidx_next     = bidx_e;
            asm_next      = asm_e;
            done_next     = done_e;
            rem_next      = rem_e;
            complete_next = s_tuser ? 1'b0 : complete_reg;
            ended_next    = ended_e;
            if (!ended_e)
            begin
                if (awaiting_e)
                begin
                    run_next      = s_tdata[7];
                    left_next     = {1'b0, s_tdata[6:0]} + 8'd1;
                    bidx_next     = 2'd0;
                    asm_next      = 32'd0;
                    awaiting_next = 1'b0;
                end
                else if (idx < bytes_per_pixel(depth_reg))
                begin
                    bidx_next = idx[1:0];
                    asm_next  = asm_new;
                end
                else
                begin
                    res_valid     = 1'b1;
                    bidx_next     = 2'd0;
                    asm_next      = 32'd0;
                    left_next     = run_e ? 8'd0 : left_dec;
                    awaiting_next = run_e || (left_dec == 8'd0);
                    done_next     = done_e + {24'd0, cnt};
                    rem_next      = rem_after;
                    if (rem_after == 32'd0)
                    begin
                        complete_next = 1'b1;
                        ended_next    = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= DEPTH_RESET;
            width_reg    <= 16'd0;
            height_reg   <= 16'd0;
            total_reg    <= 32'd0;
            settle_reg   <= 1'b0;
            awaiting_reg <= 1'b1;
            run_reg      <= 1'b0;
            left_reg     <= 8'd0;
            bidx_reg     <= 2'd0;
            asm_reg      <= 32'd0;
            done_reg     <= 32'd0;
            rem_reg      <= 32'd0;
            complete_reg <= 1'b0;
            ended_reg    <= 1'b1;
        end
        else
        begin
            depth_reg    <= depth_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            total_reg    <= total_next;
            settle_reg   <= settle_next;
            awaiting_reg <= awaiting_next;
            run_reg      <= run_next;
            left_reg     <= left_next;
            bidx_reg     <= bidx_next;
            asm_reg      <= asm_next;
            done_reg     <= done_next;
            rem_reg      <= rem_next;
            complete_reg <= complete_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

>>> rtl/tga_queue.sv
// ----------------------------------------------------------------------------
// tga_queue
// Small register queue between the byte parser and the output stage.
// ----------------------------------------------------------------------------
module tga_queue #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/tga_back.sv
// ----------------------------------------------------------------------------
// tga_back
// Output stage: takes results from the queue and holds each beat on the
// master side until it is taken.
// ----------------------------------------------------------------------------
module tga_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  tga_pkg::tga_result_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // pixel_value, repeat_count
    output logic                 m_tlast,   // image_last
    output logic                 m_tuser    // overrun
);
    import tga_pkg::*;

    logic        valid_reg, valid_next;
    tga_result_t out_reg;

    assign pop        = !empty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.repeat_count, out_reg.pixel_value};
    assign m_tlast  = out_reg.image_last;
    assign m_tuser  = out_reg.overrun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head;
        end
    end

endmodule

>>> rtl/targa_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_decoder
// Run-length pixel decoder: one coded byte per beat in, one pixel with its
// repeat count per beat out.
// ----------------------------------------------------------------------------
// a byte that completes a pixel goes into the queue, then the output register
// throughput: 1 byte per cycle while the queue has room, set by the parser
// state update; a write to image_width or image_height holds s_tready low
// while the remaining pixel count is rebuilt
// reset: packet state and pixel count clear, depth_bits 32, size 0, queue empty
module targa_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // pixel_value, repeat_count
    output logic        m_tlast,    // image_last
    output logic        m_tuser,    // overrun
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tga_pkg::*;

    localparam int RW = $bits(tga_result_t);

    tga_result_t   res, head;
    logic          res_valid, queue_full, queue_empty, pop;
    logic [RW-1:0] head_bits;

    tga_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .res_valid  (res_valid),
        .res        (res)
    );

    tga_queue #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_bits),
        .empty     (queue_empty)
    );

    assign head = tga_result_t'(head_bits);

    tga_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (queue_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/tga_checker.sv
// ----------------------------------------------------------------------------
// tga_checker
// Port-level checks for the run-length pixel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module tga_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index
);
    import tga_pkg::*;

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
    else $error("output beat changed while stalled");

    // repeat count stays within one packet
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
    else $error("repeat count out of range");

    // size change pauses the input for the account rebuild
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)
            |=> !s_tready)
    else $error("input taken while image size settles");

endmodule

bind targa_rle_pixel_decoder tga_checker u_checker (.*);

>>> tb/sv/tb_targa_rle_pixel_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_targa_rle_pixel_decoder
// Self-checking bench for the run-length pixel decoder. Coded bytes go in on
// the slave stream with random gaps. Every decoded pixel beat is checked
// field by field against a local behavioral decoder. Directed cases come
// first, then randomized frames over many depth and image size settings.
// ----------------------------------------------------------------------------
module tb_targa_rle_pixel_decoder;

    import tga_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // behavioral decoder state
    logic [7:0]  cfg_depth;
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;
    logic        hdr_wait;
    logic        run_pkt;
    logic [7:0]  pix_left;
    logic [1:0]  byte_idx;
    logic [31:0] assembly;
    logic [31:0] pixels_done;
    logic        image_full;

    tga_result_t pixel_expect_q[$];
    int unsigned decoded_bytes;
    int unsigned mismatch_count;
    bit          steady_flow;

    targa_rle_pixel_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pixel_bytes(input logic [7:0] depth);
        case (depth)
            DEPTH_8:  return 1;
            DEPTH_16: return 2;
            DEPTH_24: return 3;
            default:  return 4;
        endcase
    endfunction

    function automatic logic [31:0] image_pixels();
        return 32'(cfg_width) * 32'(cfg_height);
    endfunction

    function automatic void clear_frame_state();
        hdr_wait    = 1'b1;
        run_pkt     = 1'b0;
        pix_left    = 8'd0;
        byte_idx    = 2'd0;
        assembly    = 32'd0;
        pixels_done = 32'd0;
        image_full  = 1'b0;
    endfunction

    function automatic bit frame_finished();
        return image_full || pixels_done >= image_pixels();
    endfunction

    // returns 1 when the byte was consumed, 0 when it was ignored
    function automatic bit decode_byte(input logic [7:0] b, input logic fs);
        logic [31:0] remaining;
        logic [31:0] count;
        int unsigned idx;
        tga_result_t r;
        if (fs)
            clear_frame_state();
        if (frame_finished())
            return 0;
        if (hdr_wait)
        begin
            run_pkt  = b[7];
            pix_left = {1'b0, b[6:0]} + 8'd1;
            byte_idx = 2'd0;
            assembly = 32'd0;
            hdr_wait = 1'b0;
            return 1;
        end
        idx = byte_idx;
        assembly = assembly | (32'(b) << (8 * idx));
        idx++;
        if (idx < pixel_bytes(cfg_depth))
        begin
            byte_idx = 2'(idx);
            return 1;
        end
        r.pixel_value = assembly;
        byte_idx = 2'd0;
        assembly = 32'd0;
        remaining = image_pixels() - pixels_done;
        r.overrun = 32'(pix_left) > remaining;
        if (run_pkt)
        begin
            count = 32'(pix_left);
            pix_left = 8'd0;
        end
        else
        begin
            count = 32'd1;
            pix_left = pix_left - 8'd1;
        end
        if (count == 0)
            count = 32'd1;
        if (count > remaining)
            count = remaining;
        if (pix_left == 8'd0)
            hdr_wait = 1'b1;
        pixels_done = pixels_done + count;
        r.image_last = pixels_done >= image_pixels();
        if (r.image_last)
            image_full = 1'b1;
        r.repeat_count = count[7:0];
        pixel_expect_q.push_back(r);
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // stream and register access
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        do @(posedge clk); while (!s_tready);
        if (decode_byte(b, fs))
            decoded_bytes++;
    endtask

    // let every pending pixel drain, then give bytes in flight time to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_DEPTH:  cfg_depth  = data[7:0];
            CFG_WIDTH:  cfg_width  = data;
            CFG_HEIGHT: cfg_height = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side: random stall per beat, then compare
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        tga_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                $error("unexpected pixel beat: tdata %h last %b overrun %b",
                       m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (m_tdata[31:0] !== want.pixel_value)
                begin
                    $error("pixel_value: expected %h, got %h",
                           want.pixel_value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[39:32] !== want.repeat_count)
                begin
                    $error("repeat_count: expected %0d, got %0d",
                           want.repeat_count, m_tdata[39:32]);
                    mismatch_count++;
                end
                if (m_tlast !== want.image_last)
                begin
                    $error("image_last: expected %b, got %b", want.image_last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.overrun)
                begin
                    $error("overrun: expected %b, got %b", want.overrun, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset size is zero, so every byte is dropped
    task automatic test_unsized_image();
        send_byte(8'h81, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        settle();
    endtask

    task automatic test_literal_and_run();
        write_reg(CFG_DEPTH, {8'h00, DEPTH_8});
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd2);
        send_byte(8'h02, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hA5, 1'b0);
        // literal packet that runs past the image end
        send_byte(8'h7F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        settle();
    endtask

    task automatic test_run_clipped();
        // upper data bits must be dropped by the 8-bit depth register
        write_reg(CFG_DEPTH, {8'hAB, DEPTH_16});
        write_reg(CFG_WIDTH, 16'd2);
        write_reg(CFG_HEIGHT, 16'd2);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hAB, 1'b0);
        settle();
    endtask

    task automatic test_depth_change_mid_pixel();
        write_reg(CFG_DEPTH, {8'h00, DEPTH_32});
        write_reg(CFG_WIDTH, 16'd16);
        write_reg(CFG_HEIGHT, 16'd1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        write_reg(CFG_DEPTH, {8'h00, DEPTH_8});
        send_byte(8'h33, 1'b0);
        // unknown depth code falls back to four bytes
        write_reg(CFG_DEPTH, 16'h00FF);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b0);
        send_byte(8'h77, 1'b0);
        write_reg(CFG_DEPTH, {8'h00, DEPTH_24});
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h99, 1'b0);
        settle();
    endtask

    task automatic test_max_image();
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'hFFFF);
        write_reg(CFG_DEPTH, 16'h0000);
        send_byte(8'h7F, 1'b1);
        repeat (8) send_byte(8'($urandom), 1'b0);
        // new frame in the middle of a packet
        send_byte(8'hFE, 1'b1);
        repeat (4) send_byte(8'($urandom), 1'b0);
        write_reg(CFG_HEIGHT, 16'd0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        settle();
    endtask

    task automatic send_frame();
        int unsigned budget;
        int unsigned sent;
        int unsigned body;
        logic [7:0]  hdr;
        budget = $urandom_range(20, 80);
        sent = 0;
        hdr = {1'($urandom), 7'($urandom_range(0, 5))};
        send_byte(hdr, 1'b1);
        while (!frame_finished() && sent < budget)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                // noise byte, occasionally restarting the frame
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                sent++;
            end
            else
            begin
                if (!hdr_wait)
                    body = 1;
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        hdr = 8'($urandom);
                    else
                        hdr = {1'($urandom), 7'($urandom_range(0, 5))};
                    send_byte(hdr, 1'b0);
                    sent++;
                    body = hdr[7] ? pixel_bytes(cfg_depth)
                                  : (hdr[6:0] + 1) * pixel_bytes(cfg_depth);
                end
                // broken packet: cut the body short
                if ($urandom_range(0, 19) == 0)
                    body = $urandom_range(0, body);
                while (body != 0 && !frame_finished() && sent < budget)
                begin
                    send_byte(8'($urandom), 1'b0);
                    sent++;
                    body--;
                end
            end
        end
    endtask

    task automatic test_random_streams();
        int unsigned target;
        logic [7:0]  depth;
        target = decoded_bytes + 400;
        while (decoded_bytes < target)
        begin
            case ($urandom_range(0, 4))
                0: depth = DEPTH_8;
                1: depth = DEPTH_16;
                2: depth = DEPTH_24;
                3: depth = DEPTH_32;
                default: depth = 8'($urandom);
            endcase
            write_reg(CFG_DEPTH, {8'($urandom), depth});
            case ($urandom_range(0, 9))
                0: write_reg(CFG_WIDTH, 16'd0);
                1: write_reg(CFG_WIDTH, 16'($urandom));
                default: write_reg(CFG_WIDTH, 16'($urandom_range(1, 8)));
            endcase
            case ($urandom_range(0, 9))
                0: write_reg(CFG_HEIGHT, 16'd0);
                1: write_reg(CFG_HEIGHT, 16'($urandom));
                default: write_reg(CFG_HEIGHT, 16'($urandom_range(1, 6)));
            endcase
            steady_flow = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(1, 4)) send_frame();
            settle();
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEPTH;
        cfg_data  = 16'd0;
        cfg_depth  = DEPTH_RESET;
        cfg_width  = 16'd0;
        cfg_height = 16'd0;
        clear_frame_state();
        decoded_bytes  = 0;
        mismatch_count = 0;
        steady_flow    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unsized_image();
        test_literal_and_run();
        test_run_clipped();
        test_depth_change_mid_pixel();
        test_max_image();
        test_random_streams();

        settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/tga_pkg.sv
rtl/tga_front.sv
rtl/tga_queue.sv
rtl/tga_back.sv
rtl/targa_rle_pixel_decoder.sv
rtl/tga_checker.sv
tb/sv/tb_targa_rle_pixel_decoder.sv
